@@ hw/rtl/pcam_pkg.sv @@
// pcam_pkg: types, codes and constants of the pci config address mapper
// used by the channel interfaces, the range table, the translator and the top level
`default_nettype none

package pcam_pkg;

  // table depth default
  localparam int unsigned NumRanges = 8;

  // field widths
  localparam int unsigned BusW    = 8;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned OffsW   = 8;
  localparam int unsigned WidthW  = 2;
  localparam int unsigned AddrW   = 64;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LaneW   = 5;

  // address layout
  localparam logic [31:0] LegacyEnable = 32'h8000_0000;
  localparam int unsigned BusShift     = 20;
  localparam int unsigned DevShift     = 15;
  localparam int unsigned FuncShift    = 12;
  localparam int unsigned EcamOffW     = BusShift + BusW;

  // operation codes
  localparam logic OpTranslate = 1'b0;
  localparam logic OpInstall   = 1'b1;

  // access width codes
  localparam logic [WidthW-1:0] WidthByte  = 2'd0;
  localparam logic [WidthW-1:0] WidthWord  = 2'd1;
  localparam logic [WidthW-1:0] WidthDword = 2'd2;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  // one request item
  typedef struct packed {
    logic              operation;
    logic [BusW-1:0]   bus_num;
    logic [SlotW-1:0]  slot_num;
    logic [FuncW-1:0]  func_num;
    logic [OffsW-1:0]  reg_offset;
    logic [WidthW-1:0] access_width;
    logic [BusW-1:0]   new_start_bus;
    logic [BusW-1:0]   new_end_bus;
    logic [AddrW-1:0]  new_base;
  } req_t;

  // one result item
  typedef struct packed {
    status_e          status;
    logic             use_ecam;
    logic [AddrW-1:0] target_address;
    logic [LaneW-1:0] lane_shift;
  } rsp_t;

  // table lookup and install outcome
  typedef struct packed {
    logic             hit;
    logic [BusW-1:0]  first_bus;
    logic [AddrW-1:0] hit_base;
    status_e          install_status;
  } lookup_t;

endpackage

`default_nettype wire

@@ hw/rtl/pcam_req_if.sv @@
// pcam_req_if: request channel, valid/ready handshake with the request fields
// depends on pcam_pkg for field widths
`default_nettype none

interface pcam_req_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [pcam_pkg::BusW-1:0]         bus_num;
  logic [pcam_pkg::SlotW-1:0]        slot_num;
  logic [pcam_pkg::FuncW-1:0]        func_num;
  logic [pcam_pkg::OffsW-1:0]        reg_offset;
  logic [pcam_pkg::WidthW-1:0]       access_width;
  logic [pcam_pkg::BusW-1:0]         new_start_bus;
  logic [pcam_pkg::BusW-1:0]         new_end_bus;
  logic [pcam_pkg::AddrW-1:0]        new_base;

  modport source (
    output valid, operation, bus_num, slot_num, func_num, reg_offset,
           access_width, new_start_bus, new_end_bus, new_base,
    input  ready
  );

  modport sink (
    input  valid, operation, bus_num, slot_num, func_num, reg_offset,
           access_width, new_start_bus, new_end_bus, new_base,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/pcam_rsp_if.sv @@
// pcam_rsp_if: result channel, valid/ready handshake with the result fields
// depends on pcam_pkg for field widths
`default_nettype none

interface pcam_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pcam_pkg::StatusW-1:0]   status;
  logic                           use_ecam;
  logic [pcam_pkg::AddrW-1:0]     target_address;
  logic [pcam_pkg::LaneW-1:0]     lane_shift;

  modport source (
    output valid, status, use_ecam, target_address, lane_shift,
    input  ready
  );

  modport sink (
    input  valid, status, use_ecam, target_address, lane_shift,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/pci_config_address_mapper.sv @@
// pci_config_address_mapper: top level, input register, range table, translator, result register
// depends on pcam_pkg, pcam_req_if, pcam_rsp_if, pcam_table and pcam_xlate
//
//   channel  dir  modport  payload
//   req_i    in   sink     operation, bus/slot/func, offset, width, new range
//   rsp_o    out  source   status, use_ecam, target_address, lane_shift
//
// an item is registered in the input register on accept and its result in the result register,
// so one item is taken every cycle while the result side is ready
// an install updates the table as its result is registered, so the next item sees it
// the input register keeps taking items while a result waits, and stalls only
// when both registers hold an item and the result side is not ready
// reset clears the valid flags and the table fill count; entries need no clearing
`default_nettype none

module pci_config_address_mapper #(
  parameter int unsigned NUM_RANGES = pcam_pkg::NumRanges
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  pcam_req_if.sink      req_i,
  pcam_rsp_if.source    rsp_o
);

  logic              in_vld_q;
  pcam_pkg::req_t    in_q;
  logic              out_vld_q;
  pcam_pkg::rsp_t    out_q;
  logic              advance;
  logic              accept;
  pcam_pkg::lookup_t lookup;
  pcam_pkg::rsp_t    result;
  logic              ecam_en;

  assign advance     = !out_vld_q || rsp_o.ready;
  assign req_i.ready = !in_vld_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.operation     <= req_i.operation;
      in_q.bus_num       <= req_i.bus_num;
      in_q.slot_num      <= req_i.slot_num;
      in_q.func_num      <= req_i.func_num;
      in_q.reg_offset    <= req_i.reg_offset;
      in_q.access_width  <= req_i.access_width;
      in_q.new_start_bus <= req_i.new_start_bus;
      in_q.new_end_bus   <= req_i.new_end_bus;
      in_q.new_base      <= req_i.new_base;
    end
  end

  pcam_table #(
    .NUM_RANGES (NUM_RANGES)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (in_q),
    .commit_i  (in_vld_q && advance),
    .lookup_o  (lookup),
    .ecam_en_o (ecam_en)
  );

  pcam_xlate u_xlate (
    .req_i     (in_q),
    .lookup_i  (lookup),
    .ecam_en_i (ecam_en),
    .rsp_o     (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_q <= result;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.use_ecam       = out_q.use_ecam;
  assign rsp_o.target_address = out_q.target_address;
  assign rsp_o.lane_shift     = out_q.lane_shift;

endmodule

`default_nettype wire

@@ hw/rtl/pcam_table.sv @@
// pcam_table: ecam range table with append-only install and parallel bus match
// depends on pcam_pkg for widths, status codes and the lookup struct
`default_nettype none

module pcam_table #(
  parameter int unsigned NUM_RANGES = pcam_pkg::NumRanges
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pcam_pkg::req_t    req_i,
  input  wire logic              commit_i,
  output pcam_pkg::lookup_t      lookup_o,
  output logic                   ecam_en_o
);

  localparam int unsigned IdxW = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int unsigned CntW = $clog2(NUM_RANGES + 1);

  logic [pcam_pkg::BusW-1:0]  first_q [NUM_RANGES];
  logic [pcam_pkg::BusW-1:0]  last_q  [NUM_RANGES];
  logic [pcam_pkg::AddrW-1:0] base_q  [NUM_RANGES];

  logic [CntW-1:0] count_q, count_d;
  logic            ecam_en_q, ecam_en_d;
  logic            do_write;
  logic [IdxW-1:0] wr_idx;
  pcam_pkg::status_e status;

  // install checks: full before invalid
  always_comb begin
    if (count_q >= CntW'(NUM_RANGES)) begin
      status = pcam_pkg::STATUS_FULL;
    end else if ((req_i.new_base == '0) || (req_i.new_start_bus > req_i.new_end_bus)) begin
      status = pcam_pkg::STATUS_INVALID;
    end else begin
      status = pcam_pkg::STATUS_OK;
    end
  end

  assign do_write  = commit_i && (req_i.operation == pcam_pkg::OpInstall)
                     && (status == pcam_pkg::STATUS_OK);
  assign wr_idx    = count_q[IdxW-1:0];
  assign count_d   = do_write ? count_q + CntW'(1) : count_q;
  assign ecam_en_d = do_write ? 1'b1 : ecam_en_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ecam_en_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      ecam_en_q <= ecam_en_d;
    end
  end

  // entry storage, written at the fill position
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      first_q[wr_idx] <= req_i.new_start_bus;
      last_q[wr_idx]  <= req_i.new_end_bus;
      base_q[wr_idx]  <= req_i.new_base;
    end
  end

  // parallel compare, lowest matching entry wins
  always_comb begin
    lookup_o                = '0;
    lookup_o.install_status = status;
    for (int i = NUM_RANGES - 1; i >= 0; i--) begin
      if ((CntW'(i) < count_q) && (req_i.bus_num >= first_q[i])
          && (req_i.bus_num <= last_q[i])) begin
        lookup_o.hit       = 1'b1;
        lookup_o.first_bus = first_q[i];
        lookup_o.hit_base  = base_q[i];
      end
    end
  end

  assign ecam_en_o = ecam_en_q;

endmodule

`default_nettype wire

@@ hw/rtl/pcam_xlate.sv @@
// pcam_xlate: forms the ecam or legacy address and the byte-lane shift
// depends on pcam_pkg for the request, lookup and result structs
`default_nettype none

module pcam_xlate (
  input  wire pcam_pkg::req_t    req_i,
  input  wire pcam_pkg::lookup_t lookup_i,
  input  wire logic              ecam_en_i,
  output pcam_pkg::rsp_t         rsp_o
);

  logic [pcam_pkg::OffsW-1:0]    aligned;
  logic [pcam_pkg::BusW-1:0]     bus_delta;
  logic [pcam_pkg::EcamOffW-1:0] ecam_off;
  logic [31:0]                   legacy_word;
  logic                          hit;
  logic [pcam_pkg::LaneW-1:0]    lane;

  assign aligned   = {req_i.reg_offset[pcam_pkg::OffsW-1:2], 2'b00};
  assign bus_delta = req_i.bus_num - lookup_i.first_bus;
  assign hit       = ecam_en_i && lookup_i.hit;

  // disjoint fields, so the offset is a plain concatenation
  assign ecam_off = {bus_delta, req_i.slot_num, req_i.func_num,
                     {(pcam_pkg::FuncShift - pcam_pkg::OffsW){1'b0}}, aligned};

  assign legacy_word = pcam_pkg::LegacyEnable
                     | {8'h00, req_i.bus_num, req_i.slot_num, req_i.func_num, aligned};

  // byte-lane shift within the dword
  always_comb begin
    case (req_i.access_width)
      pcam_pkg::WidthByte: lane = {req_i.reg_offset[1:0], 3'b000};
      pcam_pkg::WidthWord: lane = {req_i.reg_offset[1], 4'b0000};
      default:             lane = '0;
    endcase
  end

  // result selection
  always_comb begin
    rsp_o = '0;
    if (req_i.operation == pcam_pkg::OpInstall) begin
      rsp_o.status = lookup_i.install_status;
    end else begin
      rsp_o.status     = pcam_pkg::STATUS_OK;
      rsp_o.use_ecam   = hit;
      rsp_o.lane_shift = lane;
      if (hit) begin
        rsp_o.target_address = lookup_i.hit_base + pcam_pkg::AddrW'(ecam_off);
      end else begin
        rsp_o.target_address = pcam_pkg::AddrW'(legacy_word);
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// tb: self-checking bench for pci_config_address_mapper, ecam range install and translation
// depends on pcam_pkg, pcam_req_if, pcam_rsp_if and the mapper rtl
`default_nettype none

module tb;
  import pcam_pkg::*;

  localparam int unsigned StallLimit = 500;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned DrainCycles = 8;
  // width code three has no name in the package, the mapper treats it as dword
  localparam logic [WidthW-1:0] WidthRsvd = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcam_req_if req_bus ();
  pcam_rsp_if rsp_bus ();

  pci_config_address_mapper u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // own copy of the range table
  logic [BusW-1:0]  tbl_first [NumRanges];
  logic [BusW-1:0]  tbl_last  [NumRanges];
  logic [AddrW-1:0] tbl_base  [NumRanges];
  int unsigned      tbl_count;
  logic             ecam_on;

  rsp_t        mapped_results [$];
  int unsigned error_count;
  int unsigned stall_cycles;
  logic        send_idle_en;
  logic        recv_idle_en;
  logic        rsp_hold;

  // result of one request, updates the table on a good install
  function automatic rsp_t map_access(input req_t r);
    rsp_t            res;
    logic [OffsW-1:0] aligned;
    logic            hit;
    res = '0;
    if (r.operation == OpInstall) begin
      if (tbl_count >= NumRanges) begin
        res.status = STATUS_FULL;
      end else if (r.new_base == '0 || r.new_start_bus > r.new_end_bus) begin
        res.status = STATUS_INVALID;
      end else begin
        tbl_first[tbl_count] = r.new_start_bus;
        tbl_last[tbl_count]  = r.new_end_bus;
        tbl_base[tbl_count]  = r.new_base;
        tbl_count++;
        ecam_on    = 1'b1;
        res.status = STATUS_OK;
      end
      return res;
    end
    aligned = r.reg_offset & 8'hFC;
    hit = 1'b0;
    // lowest matching entry wins
    if (ecam_on) begin
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (!hit && r.bus_num >= tbl_first[i] && r.bus_num <= tbl_last[i]) begin
          res.target_address = tbl_base[i]
                             + (AddrW'(r.bus_num - tbl_first[i]) << BusShift)
                             + (AddrW'(r.slot_num) << DevShift)
                             + (AddrW'(r.func_num) << FuncShift)
                             + AddrW'(aligned);
          hit = 1'b1;
        end
      end
    end
    if (!hit) begin
      res.target_address = AddrW'(LegacyEnable | (32'(r.bus_num) << 16)
                                  | (32'(r.slot_num) << 11) | (32'(r.func_num) << 8)
                                  | 32'(aligned));
    end
    res.use_ecam = hit;
    case (r.access_width)
      WidthByte: res.lane_shift = {r.reg_offset[1:0], 3'b000};
      WidthWord: res.lane_shift = {r.reg_offset[1], 4'b0000};
      default:   res.lane_shift = '0;
    endcase
    return res;
  endfunction

  function automatic req_t translate_req(input logic [BusW-1:0] bus,
                                         input logic [SlotW-1:0] slot,
                                         input logic [FuncW-1:0] func,
                                         input logic [OffsW-1:0] offs,
                                         input logic [WidthW-1:0] width);
    req_t r;
    r.operation     = OpTranslate;
    r.bus_num       = bus;
    r.slot_num      = slot;
    r.func_num      = func;
    r.reg_offset    = offs;
    r.access_width  = width;
    r.new_start_bus = BusW'($urandom);
    r.new_end_bus   = BusW'($urandom);
    r.new_base      = {$urandom, $urandom};
    return r;
  endfunction

  function automatic req_t install_req(input logic [BusW-1:0] first,
                                       input logic [BusW-1:0] last,
                                       input logic [AddrW-1:0] base);
    req_t r;
    r.operation     = OpInstall;
    r.bus_num       = BusW'($urandom);
    r.slot_num      = SlotW'($urandom);
    r.func_num      = FuncW'($urandom);
    r.reg_offset    = OffsW'($urandom);
    r.access_width  = WidthW'($urandom);
    r.new_start_bus = first;
    r.new_end_bus   = last;
    r.new_base      = base;
    return r;
  endfunction

  // mostly translations aimed at installed ranges, now and then an install
  function automatic req_t random_req();
    logic [BusW-1:0]  lo;
    logic [BusW-1:0]  hi;
    logic [BusW-1:0]  bus;
    logic [AddrW-1:0] base;
    int unsigned      pick;
    if ($urandom_range(0, 47) == 0) begin
      lo   = BusW'($urandom_range(0, 255));
      hi   = (lo > 8'd240) ? 8'hFF : BusW'(lo + $urandom_range(0, 15));
      base = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: base = '0;
        1: begin
          lo = BusW'($urandom_range(1, 255));
          hi = BusW'($urandom_range(0, lo - 1));
        end
        2: base = {32'hFFFF_FFFF, $urandom};
        3: base[27:0] = '0;
        default: ;
      endcase
      return install_req(lo, hi, base);
    end
    bus = BusW'($urandom_range(0, 255));
    if (tbl_count != 0 && $urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, tbl_count - 1);
      bus  = BusW'($urandom_range(tbl_first[pick], tbl_last[pick]));
    end
    return translate_req(bus, SlotW'($urandom), FuncW'($urandom), OffsW'($urandom),
                         WidthW'($urandom_range(0, 3)));
  endfunction

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] got,
                                 input logic [AddrW-1:0] want);
    error_count++;
    $display("mismatch at %0t on %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // offer one item, with a random gap ahead of it, and wait for accept
  task automatic send_item(input req_t r);
    int unsigned gap;
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid         <= 1'b1;
    req_bus.operation     <= r.operation;
    req_bus.bus_num       <= r.bus_num;
    req_bus.slot_num      <= r.slot_num;
    req_bus.func_num      <= r.func_num;
    req_bus.reg_offset    <= r.reg_offset;
    req_bus.access_width  <= r.access_width;
    req_bus.new_start_bus <= r.new_start_bus;
    req_bus.new_end_bus   <= r.new_end_bus;
    req_bus.new_base      <= r.new_base;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // predict every accepted request
  always @(posedge clk_i) begin : predict_requests
    req_t r;
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      r = {req_bus.operation, req_bus.bus_num, req_bus.slot_num, req_bus.func_num,
           req_bus.reg_offset, req_bus.access_width, req_bus.new_start_bus,
           req_bus.new_end_bus, req_bus.new_base};
      mapped_results.push_back(map_access(r));
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (mapped_results.size() == 0) begin
        report_mismatch("unexpected result", rsp_bus.target_address, '0);
      end else begin
        want = mapped_results.pop_front();
        if (rsp_bus.status !== want.status)
          report_mismatch("status", AddrW'(rsp_bus.status), AddrW'(want.status));
        if (rsp_bus.use_ecam !== want.use_ecam)
          report_mismatch("use_ecam", AddrW'(rsp_bus.use_ecam), AddrW'(want.use_ecam));
        if (rsp_bus.target_address !== want.target_address)
          report_mismatch("target_address", rsp_bus.target_address, want.target_address);
        if (rsp_bus.lane_shift !== want.lane_shift)
          report_mismatch("lane_shift", AddrW'(rsp_bus.lane_shift), AddrW'(want.lane_shift));
      end
    end
  end

  // result side ready, with random bursts low and one long hold on request
  initial begin : drive_ready
    int unsigned low;
    rsp_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rsp_hold) begin
        rsp_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rsp_hold = 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 3) == 0) begin
        low = $urandom_range(1, 5);
        rsp_bus.ready <= 1'b0;
        repeat (low) @(posedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // end the run when no item moves for too long
  always @(posedge clk_i) begin : watchdog
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no item moved for %0d cycles", StallLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ecam still off, every access takes the legacy word
  task automatic test_legacy_before_enable();
    send_item(translate_req(8'h00, 5'h00, 3'h0, 8'h00, WidthByte));
    send_item(translate_req(8'hFF, 5'h1F, 3'h7, 8'hFF, WidthByte));
    send_item(translate_req(8'hFF, 5'h1F, 3'h7, 8'hFE, WidthWord));
    send_item(translate_req(8'hA5, 5'h15, 3'h5, 8'h5A, WidthDword));
    send_item(translate_req(8'h5A, 5'h0A, 3'h2, 8'hA7, WidthRsvd));
  endtask

  // rejected installs leave ecam off
  task automatic test_install_checks();
    send_item(install_req(8'd30, 8'd20, 64'h0000_0000_E000_0000));
    send_item(install_req(8'd5, 8'd5, 64'h0));
    send_item(translate_req(8'd5, 5'h03, 3'h1, 8'h13, WidthWord));
  endtask

  // hits, misses, wrap of the sum and overlapping ranges
  task automatic test_ecam_translate();
    send_item(install_req(8'd16, 8'd31, 64'hFFFF_FFFF_FFF0_0000));
    send_item(translate_req(8'd31, 5'h1F, 3'h7, 8'hFF, WidthByte));
    send_item(translate_req(8'd16, 5'h00, 3'h0, 8'h00, WidthDword));
    send_item(translate_req(8'd15, 5'h11, 3'h6, 8'h42, WidthWord));
    send_item(install_req(8'd24, 8'd63, 64'h0000_0000_E000_0000));
    send_item(translate_req(8'd24, 5'h08, 3'h3, 8'h81, WidthByte));
    send_item(translate_req(8'd40, 5'h1E, 3'h4, 8'hC6, WidthWord));
    send_item(install_req(8'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_item(translate_req(8'd0, 5'h01, 3'h1, 8'h04, WidthDword));
    send_item(install_req(8'd255, 8'd255, 64'h1));
    send_item(translate_req(8'd255, 5'h1F, 3'h7, 8'hFD, WidthRsvd));
  endtask

  // hold the result side off while requests keep coming
  task automatic test_output_stall();
    send_idle_en = 1'b0;
    rsp_hold = 1'b1;
    for (int i = 0; i < 24; i++) send_item(random_req());
  endtask

  task automatic test_random_traffic(input int unsigned count, input logic idling);
    send_idle_en = idling;
    recv_idle_en = idling;
    for (int unsigned i = 0; i < count; i++) send_item(random_req());
  endtask

  // fill every slot, then full wins over an invalid range
  task automatic test_table_full();
    logic [BusW-1:0] lo;
    for (int unsigned i = 0; i <= NumRanges; i++) begin
      lo = BusW'($urandom_range(0, 200));
      send_item(install_req(lo, BusW'(lo + $urandom_range(0, 40)),
                            {$urandom, $urandom} | 64'h1000));
    end
    send_item(install_req(8'd200, 8'd100, 64'h0000_0000_C000_0000));
    send_item(install_req(8'd10, 8'd20, 64'h0));
    for (int i = 0; i < 3; i++) send_item(random_req());
  endtask

  initial begin
    rst_ni                = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.operation     = OpTranslate;
    req_bus.bus_num       = '0;
    req_bus.slot_num      = '0;
    req_bus.func_num      = '0;
    req_bus.reg_offset    = '0;
    req_bus.access_width  = WidthByte;
    req_bus.new_start_bus = '0;
    req_bus.new_end_bus   = '0;
    req_bus.new_base      = '0;
    tbl_count             = 0;
    ecam_on               = 1'b0;
    error_count           = 0;
    stall_cycles          = 0;
    send_idle_en          = 1'b1;
    recv_idle_en          = 1'b1;
    rsp_hold              = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_legacy_before_enable();
    test_install_checks();
    test_ecam_translate();
    test_output_stall();
    for (int chunk = 0; chunk < 8; chunk++) test_random_traffic(90, (chunk % 3) != 2);
    test_table_full();
    test_random_traffic(80, 1'b0);

    // drain
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (mapped_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
